@@ rtl/core/dmx_channel_htp_grand_master_core_defines.svh @@
// Assertion macros shared by the DMX HTP grand master core.
`ifndef DMX_CHANNEL_HTP_GRAND_MASTER_CORE_DEFINES_SVH
`define DMX_CHANNEL_HTP_GRAND_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DMXHTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DMXHTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dmxhtp_pkg.sv @@
// Types, constants and codes of the DMX HTP grand master core.
package dmxhtp_pkg;

    localparam int UNIVERSE_SIZE = 512;
    localparam int ADDR_W        = (UNIVERSE_SIZE > 1) ? $clog2(UNIVERSE_SIZE) : 1;
    localparam int CH_W          = 9;
    localparam int LVL_W         = 8;
    localparam int OFF_W         = 16;
    localparam int CFG_ADDR_W    = 2;

    localparam logic [LVL_W-1:0] LEVEL_MAX   = 8'd255;
    localparam logic [LVL_W-1:0] STEP_CENTER = 8'd127;

    // round(v*g/255) = (2*v*g + 255) / 510, divide done by reciprocal
    localparam int SCALE_DIV  = 510;
    localparam int SCALE_BIAS = 255;
    localparam int RCP_SHIFT  = 26;
    localparam int RCP_MUL    = (1 << RCP_SHIFT) / SCALE_DIV;
    localparam int PROD_W     = 17;
    localparam int RCP_W      = 18;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MASTER_LEVEL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT_MODE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALL_CHANNELS = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_MASTER,
        ST_WB
    } t_state;

    // one channel's memory word
    typedef struct packed {
        logic [LVL_W-1:0]        pre;
        logic [LVL_W-1:0]        post;
        logic signed [OFF_W-1:0] offset;
        logic                    int_member;
        logic                    oth_member;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // command to the master unit
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] gain;
        logic             limit;
        logic             apply;
    } t_master_cmd;

endpackage

@@ rtl/core/dmx_channel_htp_grand_master_core.sv @@
// Top level: DMX channel HTP merge with relative offsets and grand master.
//
// One channel write per beat on the input channel, one result beat per write.
// All per-channel state (pre-master level, post-master level, 16-bit
// saturating relative offset, intensity and non-intensity membership) lives in
// one 512-entry RAM word per channel with registered read data; each write is
// a read-modify-write of that word, one write in flight at a time. After reset
// the core sweeps the RAM to zero, one entry per cycle, while o_ready stays
// low (configuration writes still land). A write whose level goes through the
// grand master passes RAM read, offset mix, 3-stage master pipeline and
// writeback; writes that end early (HTP reject, neutral relative step, channel
// out of range) skip the master and go from the mix straight to writeback.
// The result sits in an output register, so the next write is taken while it
// waits; a write stalls in writeback only if the previous result has not been
// taken. Configuration is sampled when a write enters the master, so change
// it only while the core is idle.
`include "dmx_channel_htp_grand_master_core_defines.svh"

module dmx_channel_htp_grand_master_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [dmxhtp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dmxhtp_pkg::LVL_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [dmxhtp_pkg::CH_W-1:0]           i_channel,
    input  logic [dmxhtp_pkg::LVL_W-1:0]          i_level,
    input  logic                                  i_is_intensity,
    input  logic                                  i_relative,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_accepted,
    output logic [dmxhtp_pkg::LVL_W-1:0]          o_out_level
);

    localparam int AW  = dmxhtp_pkg::ADDR_W;
    localparam int LW  = dmxhtp_pkg::LVL_W;
    localparam int OW  = dmxhtp_pkg::OFF_W;
    localparam int CW  = dmxhtp_pkg::CH_W;

    dmxhtp_pkg::t_state r_state, n_state;

    // clear sweep
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    // any non-neutral relative step on an in-range channel seen since reset
    logic          r_seen, n_seen;
    // captured write
    logic [CW-1:0] r_ch;
    logic [LW-1:0] r_lv;
    logic          r_intens;
    logic          r_rel;
    // pending writeback and result
    dmxhtp_pkg::t_entry r_ent, n_ent;
    logic          r_wr, n_wr;
    logic          r_res_acc, n_res_acc;
    logic [LW-1:0] r_res_level, n_res_level;
    // output register
    logic          r_o_valid, n_o_valid;
    logic          r_o_acc;
    logic [LW-1:0] r_o_level;
    logic          load_out;
    // configuration
    logic [LW-1:0] r_master_level;
    logic          r_limit;
    logic          r_all;

    // RAM
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    dmxhtp_pkg::t_entry         ram_wdata;
    dmxhtp_pkg::t_entry         ram_rdata;
    logic [dmxhtp_pkg::ENTRY_W-1:0] ram_rdata_raw;

    // master unit
    logic                       m_start;
    dmxhtp_pkg::t_master_cmd    m_cmd;
    logic                       m_done;
    logic [LW-1:0]              m_result;

    // mix datapath
    logic                       in_accept;
    logic                       in_range;
    logic signed [8:0]          step;
    logic signed [OW:0]         off_sum;
    logic signed [OW-1:0]       off_sat;
    logic signed [OW-1:0]       new_off;
    logic [LW-1:0]              pre_new;
    logic signed [OW+1:0]       mix_sum;
    logic [LW-1:0]              mix_clamp;
    logic [LW-1:0]              pre_master;

    assign in_accept = i_valid && o_ready;
    assign ram_rdata = dmxhtp_pkg::t_entry'(ram_rdata_raw);

    dmxhtp_ram #(
        .WIDTH (dmxhtp_pkg::ENTRY_W),
        .DEPTH (dmxhtp_pkg::UNIVERSE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(i_channel)),
        .o_rdata (ram_rdata_raw)
    );

    dmxhtp_master u_master (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (m_start),
        .i_cmd    (m_cmd),
        .o_done   (m_done),
        .o_result (m_result)
    );

    // offset update and pre-master mix, from the RAM word read at accept
    always_comb begin
        in_range = 32'(r_ch) < dmxhtp_pkg::UNIVERSE_SIZE;
        step     = $signed({1'b0, r_lv}) - $signed({1'b0, dmxhtp_pkg::STEP_CENTER});
        off_sum  = {ram_rdata.offset[OW-1], ram_rdata.offset} + {{(OW-8){step[8]}}, step};
        if (off_sum[OW] != off_sum[OW-1]) begin
            off_sat = off_sum[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
        end else begin
            off_sat = off_sum[OW-1:0];
        end
        new_off = r_rel ? off_sat : ram_rdata.offset;
        pre_new = r_rel ? ram_rdata.pre : r_lv;
        mix_sum = {{2{new_off[OW-1]}}, new_off} + {{(OW+2-LW){1'b0}}, pre_new};
        if (mix_sum[OW+1]) begin
            mix_clamp = '0;
        end else if (mix_sum[OW:LW] != '0) begin
            mix_clamp = dmxhtp_pkg::LEVEL_MAX;
        end else begin
            mix_clamp = mix_sum[LW-1:0];
        end
        // a relative write here always makes the offset live
        pre_master = (r_seen || r_rel) ? mix_clamp : r_lv;

        m_cmd.level = pre_master;
        m_cmd.gain  = r_master_level;
        m_cmd.limit = r_limit;
        m_cmd.apply = r_intens || r_all;
    end

    // next state and control
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_seen      = r_seen;
        n_ent       = r_ent;
        n_wr        = r_wr;
        n_res_acc   = r_res_acc;
        n_res_level = r_res_level;
        n_o_valid   = r_o_valid;
        load_out    = 1'b0;
        m_start     = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_ch);
        ram_wdata   = r_ent;
        o_ready     = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            dmxhtp_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == AW'(dmxhtp_pkg::UNIVERSE_SIZE - 1)) begin
                    n_state = dmxhtp_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            dmxhtp_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (in_accept) begin
                    n_state = dmxhtp_pkg::ST_MIX;
                end
            end
            dmxhtp_pkg::ST_MIX: begin
                n_wr        = 1'b0;
                n_res_level = ram_rdata.post;
                n_state     = dmxhtp_pkg::ST_WB;
                if (!in_range) begin
                    n_res_acc   = 1'b0;
                    n_res_level = '0;
                end else if (r_rel && r_lv == dmxhtp_pkg::STEP_CENTER) begin
                    n_res_acc = 1'b1;
                end else if (!r_rel && r_intens && r_lv < ram_rdata.pre) begin
                    // highest takes precedence
                    n_res_acc = 1'b0;
                end else begin
                    n_res_acc    = 1'b1;
                    n_wr         = 1'b1;
                    n_ent        = ram_rdata;
                    n_ent.pre    = pre_new;
                    n_ent.offset = new_off;
                    if (r_intens) begin
                        n_ent.int_member = (pre_master != '0);
                    end else begin
                        n_ent.oth_member = (pre_master != '0);
                    end
                    if (r_rel) begin
                        n_seen = 1'b1;
                    end
                    m_start = 1'b1;
                    n_state = dmxhtp_pkg::ST_MASTER;
                end
            end
            dmxhtp_pkg::ST_MASTER: begin
                if (m_done) begin
                    n_ent.post  = m_result;
                    n_res_level = m_result;
                    n_state     = dmxhtp_pkg::ST_WB;
                end
            end
            dmxhtp_pkg::ST_WB: begin
                if (!r_o_valid || i_ready) begin
                    ram_we    = r_wr;
                    load_out  = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = dmxhtp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dmxhtp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dmxhtp_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_seen     <= 1'b0;
            r_wr       <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_seen     <= n_seen;
            r_wr       <= n_wr;
            r_o_valid  <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch     <= i_channel;
            r_lv     <= i_level;
            r_intens <= i_is_intensity;
            r_rel    <= i_relative;
        end
        r_ent       <= n_ent;
        r_res_acc   <= n_res_acc;
        r_res_level <= n_res_level;
        if (load_out) begin
            r_o_acc   <= r_res_acc;
            r_o_level <= r_res_level;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_level <= dmxhtp_pkg::LEVEL_MAX;
            r_limit        <= 1'b0;
            r_all          <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dmxhtp_pkg::CFG_MASTER_LEVEL: r_master_level <= i_cfg_data;
                dmxhtp_pkg::CFG_LIMIT_MODE:   r_limit        <= i_cfg_data[0];
                dmxhtp_pkg::CFG_ALL_CHANNELS: r_all          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_accepted  = r_o_acc;
    assign o_out_level = r_o_level;

    `DMXHTP_ASSERT_NEXT(a_accept_to_mix, in_accept, r_state == dmxhtp_pkg::ST_MIX, "accepted beat did not go to mix")
    `DMXHTP_ASSERT_NEXT(a_wb_loads_out, (r_state == dmxhtp_pkg::ST_WB) && (n_state == dmxhtp_pkg::ST_IDLE), r_o_valid, "writeback left no result beat")
    `DMXHTP_ASSERT_NOW(a_out_drop_only_taken, $fell(r_o_valid), $past(i_ready), "result beat dropped before taken")

endmodule

@@ rtl/core/dmxhtp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module dmxhtp_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/dmxhtp_master.sv @@
// Grand master unit: limit, scale or pass through a level, three-stage pipeline.
`include "dmx_channel_htp_grand_master_core_defines.svh"

module dmxhtp_master (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  dmxhtp_pkg::t_master_cmd  i_cmd,
    output logic                     o_done,
    output logic [dmxhtp_pkg::LVL_W-1:0] o_result
);

    localparam int LW = dmxhtp_pkg::LVL_W;
    localparam int PW = dmxhtp_pkg::PROD_W;
    localparam int QW = LW + 1;

    // stage 1: product 2*v*g + 255
    logic                r_v1;
    dmxhtp_pkg::t_master_cmd r_cmd1;
    logic [PW-1:0]       r_prod1;
    // stage 2: reciprocal multiply
    logic                r_v2;
    dmxhtp_pkg::t_master_cmd r_cmd2;
    logic [PW-1:0]       r_prod2;
    logic [QW-1:0]       r_q0;
    // stage 3: result
    logic                r_done;
    logic [LW-1:0]       r_result;

    logic [PW-1:0]                          n_prod1;
    logic [PW+dmxhtp_pkg::RCP_W-1:0]        rcp_full;
    logic [PW:0]                            q0_x_div;
    logic [PW:0]                            rem;
    logic [QW-1:0]                          q_fix;
    logic [LW-1:0]                          n_result;

    assign n_prod1 = PW'({i_cmd.level, 1'b0}) * PW'(i_cmd.gain)
                   + PW'(dmxhtp_pkg::SCALE_BIAS);
    assign rcp_full = (PW+dmxhtp_pkg::RCP_W)'(r_prod1)
                    * (PW+dmxhtp_pkg::RCP_W)'(dmxhtp_pkg::RCP_MUL);

    // q0 is the quotient or one short; one compare fixes it
    always_comb begin
        q0_x_div = ((PW+1)'(r_q0) << 9) - ((PW+1)'(r_q0) << 1);
        rem      = (PW+1)'(r_prod2) - q0_x_div;
        q_fix    = (rem >= (PW+1)'(dmxhtp_pkg::SCALE_DIV)) ? (r_q0 + QW'(1)) : r_q0;
        if (r_cmd2.level == '0) begin
            n_result = '0;
        end else if (!r_cmd2.apply) begin
            n_result = r_cmd2.level;
        end else if (r_cmd2.limit) begin
            n_result = (r_cmd2.level > r_cmd2.gain) ? r_cmd2.gain : r_cmd2.level;
        end else begin
            n_result = q_fix[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd1  <= i_cmd;
            r_prod1 <= n_prod1;
        end
        if (r_v1) begin
            r_cmd2  <= r_cmd1;
            r_prod2 <= r_prod1;
            r_q0    <= rcp_full[dmxhtp_pkg::RCP_SHIFT +: QW];
        end
        if (r_v2) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `DMXHTP_ASSERT_NOW(a_done_latency, o_done, $past(i_start, 3), "master done without start three cycles back")

endmodule
